FILE: hdl/nir_pkg.sv
package nir_pkg;

	localparam int unsigned CHAN_W  = 3;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned FRAME_W = 32;

	localparam logic [TIME_W-1:0] ZERO_MIN   = 16'd100;
	localparam logic [TIME_W-1:0] ZERO_MAX   = 16'd150;
	localparam logic [TIME_W-1:0] ONE_MIN    = 16'd200;
	localparam logic [TIME_W-1:0] ONE_MAX    = 16'd250;
	localparam logic [TIME_W-1:0] HEADER_MIN = 16'd1300;
	localparam logic [TIME_W-1:0] HEADER_MAX = 16'd1500;

	localparam logic [COUNT_W-1:0] LAST_BIT = 6'd31;

	typedef struct packed {
		logic               edge_seen;
		logic [TIME_W-1:0]  last_edge_time;
		logic               in_frame;
		logic [COUNT_W-1:0] bit_count;
		logic [FRAME_W-1:0] shift_bits;
	} chan_state_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  source_channel;
		logic [FRAME_W-1:0] raw_frame;
		logic               frame_valid;
		logic [7:0]         command;
	} result_t;

endpackage

FILE: hdl/nir_step.sv
module nir_step (
	input  nir_pkg::chan_state_t          cur,
	input  logic [nir_pkg::CHAN_W-1:0]    channel,
	input  logic [nir_pkg::TIME_W-1:0]    timestamp,
	input  logic [7:0]                    device_address,
	output nir_pkg::chan_state_t          nxt,
	output logic                          fire,
	output nir_pkg::result_t              result
);
	import nir_pkg::*;

	logic [TIME_W-1:0]  len;
	logic [FRAME_W-1:0] shifted;
	logic               is_zero;
	logic               is_one;
	logic               is_header;
	logic               ok;

	// An edge at or before the previous one is taken to have wrapped once.
	assign len = timestamp - cur.last_edge_time
		- ((timestamp > cur.last_edge_time) ? 16'd0 : 16'd1);

	assign is_zero   = (len > ZERO_MIN) && (len < ZERO_MAX);
	assign is_one    = (len > ONE_MIN) && (len < ONE_MAX);
	assign is_header = (len > HEADER_MIN) && (len < HEADER_MAX);
	assign shifted   = {cur.shift_bits[FRAME_W-2:0], is_one};

	assign ok = (shifted[31:24] == ~shifted[23:16]) && (shifted[31:24] == device_address)
		&& (shifted[15:8] == ~shifted[7:0]);

	always_comb begin
		nxt  = cur;
		fire = 1'b0;
		if (!cur.edge_seen) begin
			nxt.edge_seen      = 1'b1;
			nxt.last_edge_time = timestamp;
		end else begin
			nxt.last_edge_time = timestamp;
			if (!cur.in_frame) begin
				if (is_header) begin
					nxt.in_frame   = 1'b1;
					nxt.bit_count  = '0;
					nxt.shift_bits = '0;
				end
			end else if (is_zero || is_one) begin
				nxt.shift_bits = shifted;
				if (cur.bit_count == LAST_BIT) begin
					fire          = 1'b1;
					nxt.in_frame  = 1'b0;
					nxt.bit_count = '0;
				end else begin
					nxt.bit_count = cur.bit_count + 6'd1;
				end
			end else begin
				nxt.in_frame  = 1'b0;
				nxt.bit_count = '0;
			end
		end
	end

	assign result.source_channel = channel;
	assign result.raw_frame      = shifted;
	assign result.frame_valid    = ok;
	assign result.command        = ok ? shifted[15:8] : 8'd0;

endmodule

FILE: hdl/nir_out_reg.sv
module nir_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  nir_pkg::result_t load_data,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output nir_pkg::result_t out_data
);
	import nir_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= load_data;
		end
	end

endmodule

FILE: hdl/nec_ir_multichannel_decoder_core.sv
// NEC infrared decoder for several receivers sharing one event stream.
// Each transfer on the input channel (in_valid/in_ready, channel, timestamp)
// reports one falling edge of one receiver, stamped by a 10 us counter.
// Edges on a channel number at or above CHANNELS are dropped silently.
// When a channel completes its 32 data bits, one result transfer appears on
// the output channel (out_valid/out_ready) with the channel, the raw frame,
// the check flag and the command byte.
// The input register takes one edge per cycle while in_ready is high; a result
// is loaded into the output register when its edge leaves the input register.
// The per-channel state is read, updated and written back in the same cycle,
// so consecutive edges of the same channel follow each other without a gap.
// If the receiver stalls, edges that complete no frame keep flowing; an edge
// that completes a frame waits in the input register until the output
// register frees, and the input is held off meanwhile.
// The device address is written through cfg_valid/cfg_ready/device_address;
// cfg_ready is always high and a write takes effect at the next edge.
// Reset clears all channel state, both registers' valid flags and the
// device address.
module nec_ir_multichannel_decoder_core #(
	parameter int unsigned CHANNELS = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [nir_pkg::CHAN_W-1:0]   channel,
	input  logic [nir_pkg::TIME_W-1:0]   timestamp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [7:0]                   device_address,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [nir_pkg::CHAN_W-1:0]   source_channel,
	output logic [nir_pkg::FRAME_W-1:0]  raw_frame,
	output logic                         frame_valid,
	output logic [7:0]                   command
);
	import nir_pkg::*;

	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	chan_state_t        state_q [CHANNELS];
	logic [7:0]         address_q;
	logic               valid_s1;
	logic [CHAN_W-1:0]  channel_s1;
	logic [TIME_W-1:0]  timestamp_s1;
	logic [4:0]         chan_ext;
	logic [IDX_W-1:0]   idx;
	logic               in_range;
	chan_state_t        cur;
	chan_state_t        nxt;
	logic               fire;
	result_t            result;
	result_t            out_data;
	logic               can_load;
	logic               advance;

	assign chan_ext = {2'b00, channel_s1};
	assign idx      = chan_ext[IDX_W-1:0];
	assign in_range = chan_ext < 5'(CHANNELS);
	assign cur      = state_q[idx];

	nir_step u_step (
		.cur            (cur),
		.channel        (channel_s1),
		.timestamp      (timestamp_s1),
		.device_address (address_q),
		.nxt            (nxt),
		.fire           (fire),
		.result         (result)
	);

	assign advance   = valid_s1 && (!(fire && in_range) || can_load);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	nir_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && in_range && fire),
		.load_data (result),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign source_channel = out_data.source_channel;
	assign raw_frame      = out_data.raw_frame;
	assign frame_valid    = out_data.frame_valid;
	assign command        = out_data.command;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			channel_s1   <= channel;
			timestamp_s1 <= timestamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			address_q <= device_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else if (advance && in_range) begin
			state_q[idx] <= nxt;
		end
	end

endmodule

FILE: sim/nec_ir_multichannel_decoder_core_tb.sv
`timescale 1ns / 1ps

module nec_ir_multichannel_decoder_core_tb;

	import nir_pkg::*;

	localparam int unsigned NUM_CH = 5;
	localparam int unsigned RANDOM_EDGES = 1250;
	localparam int unsigned PHASES = 5;
	localparam int unsigned SETTLE = 6;
	localparam int unsigned DIRECTED_ROWS = 26;
	localparam int unsigned TIMEOUT_NS = 5_000_000;

	typedef struct packed {
		logic [CHAN_W-1:0] ch;
		logic [TIME_W-1:0] ts;
		bit                quiet;
	} edge_row_t;

	typedef enum int unsigned {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_HOLD
	} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CHAN_W-1:0]   channel = '0;
	logic [TIME_W-1:0]   timestamp = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [7:0]          device_address = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CHAN_W-1:0]   source_channel;
	logic [FRAME_W-1:0]  raw_frame;
	logic                frame_valid;
	logic [7:0]          command;

	logic                seen_q   [NUM_CH];
	logic [TIME_W-1:0]   last_ts  [NUM_CH];
	logic                framing  [NUM_CH];
	logic [COUNT_W-1:0]  nbits    [NUM_CH];
	logic [FRAME_W-1:0]  shreg    [NUM_CH];
	logic [7:0]          want_address = '0;

	result_t             frames_due [$];
	int unsigned         pulse_plan [NUM_CH][$];
	int unsigned         failures = 0;

	nec_ir_multichannel_decoder_core #(
		.CHANNELS(NUM_CH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel(channel),
		.timestamp(timestamp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.device_address(device_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.source_channel(source_channel),
		.raw_frame(raw_frame),
		.frame_valid(frame_valid),
		.command(command)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit decode_edge(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] now,
			output result_t r);
		logic [TIME_W-1:0]  len;
		logic [FRAME_W-1:0] f;
		bit                 ok;
		r = '0;
		if (ch >= NUM_CH)
			return 1'b0;
		if (!seen_q[ch]) begin
			seen_q[ch] = 1'b1;
			last_ts[ch] = now;
			return 1'b0;
		end
		if (now > last_ts[ch])
			len = now - last_ts[ch];
		else
			len = 16'hFFFF - last_ts[ch] + now;
		last_ts[ch] = now;
		if (!framing[ch]) begin
			if (len > HEADER_MIN && len < HEADER_MAX) begin
				framing[ch] = 1'b1;
				nbits[ch] = '0;
				shreg[ch] = '0;
			end
			return 1'b0;
		end
		if (len > ZERO_MIN && len < ZERO_MAX) begin
			shreg[ch] = {shreg[ch][FRAME_W-2:0], 1'b0};
		end else if (len > ONE_MIN && len < ONE_MAX) begin
			shreg[ch] = {shreg[ch][FRAME_W-2:0], 1'b1};
		end else begin
			framing[ch] = 1'b0;
			nbits[ch] = '0;
			return 1'b0;
		end
		nbits[ch] = nbits[ch] + 1'b1;
		if (nbits[ch] < FRAME_W)
			return 1'b0;
		f = shreg[ch];
		ok = (f[31:24] == ~f[23:16]) && (f[31:24] == want_address) && (f[15:8] == ~f[7:0]);
		framing[ch] = 1'b0;
		nbits[ch] = '0;
		r.source_channel = ch;
		r.raw_frame = f;
		r.frame_valid = ok;
		r.command = ok ? f[15:8] : 8'h00;
		return 1'b1;
	endfunction

	function automatic logic [TIME_W-1:0] stamp_after(input logic [TIME_W-1:0] last,
			input int unsigned gap);
		logic [TIME_W-1:0] next;
		next = last + TIME_W'(gap);
		// Past a wrap the interval reads one short, so step one count further.
		if (next <= last)
			next = next + 1'b1;
		return next;
	endfunction

	function automatic int unsigned stray_gap();
		case ($urandom_range(7))
			0: return ZERO_MIN;
			1: return ZERO_MAX;
			2: return ONE_MIN;
			3: return ONE_MAX;
			4: return 175;
			5: return $urandom_range(HEADER_MIN + 1, HEADER_MAX - 1);
			6: return HEADER_MIN;
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	function automatic void plan_frame(input int unsigned ch);
		logic [7:0]         a;
		logic [7:0]         na;
		logic [7:0]         c;
		logic [7:0]         nc;
		logic [FRAME_W-1:0] f;
		a = ($urandom_range(9) < 7) ? want_address : 8'($urandom);
		na = ($urandom_range(7) != 0) ? ~a : 8'($urandom);
		c = 8'($urandom);
		nc = ($urandom_range(7) != 0) ? ~c : 8'($urandom);
		f = {a, na, c, nc};
		if ($urandom_range(15) == 0)
			f = $urandom;
		pulse_plan[ch].push_back($urandom_range(HEADER_MIN + 1, HEADER_MAX - 1));
		for (int i = FRAME_W - 1; i >= 0; i--) begin
			if ($urandom_range(249) == 0)
				pulse_plan[ch].push_back(stray_gap());
			else if (f[i])
				pulse_plan[ch].push_back($urandom_range(ONE_MIN + 1, ONE_MAX - 1));
			else
				pulse_plan[ch].push_back($urandom_range(ZERO_MIN + 1, ZERO_MAX - 1));
		end
	endfunction

	function automatic void plan_noise(input int unsigned ch);
		int unsigned n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			case ($urandom_range(4))
				0: pulse_plan[ch].push_back($urandom_range(1100, 1150));
				1: pulse_plan[ch].push_back(HEADER_MIN);
				2: pulse_plan[ch].push_back(HEADER_MAX);
				3: pulse_plan[ch].push_back($urandom_range(ZERO_MIN + 1, ONE_MAX - 1));
				default: pulse_plan[ch].push_back($urandom_range(1, 65535));
			endcase
		end
	endfunction

	task automatic push_edge(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] ts,
			input bit quiet);
		result_t r;
		bit      got;
		@(negedge clk);
		in_valid <= 1'b1;
		channel <= ch;
		timestamp <= ts;
		do @(posedge clk); while (!in_ready);
		got = decode_edge(ch, ts, r);
		if (got && !quiet)
			frames_due.push_back(r);
	endtask

	task automatic idle_input(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_address(input logic [7:0] addr);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		device_address <= addr;
		do @(posedge clk); while (!cfg_ready);
		want_address = addr;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				$error("unexpected result transfer: source_channel %0d raw_frame %h",
					source_channel, raw_frame);
				failures++;
			end else begin
				want = frames_due.pop_front();
				if (source_channel !== want.source_channel) begin
					$error("source_channel: expected %0d, actual %0d",
						want.source_channel, source_channel);
					failures++;
				end
				if (raw_frame !== want.raw_frame) begin
					$error("raw_frame: expected %h, actual %h", want.raw_frame, raw_frame);
					failures++;
				end
				if (frame_valid !== want.frame_valid) begin
					$error("frame_valid: expected %0d, actual %0d", want.frame_valid, frame_valid);
					failures++;
				end
				if (command !== want.command) begin
					$error("command: expected %h, actual %h", want.command, command);
					failures++;
				end
			end
		end
	end

	initial begin
		rx_mode_t    mode;
		int unsigned span;
		forever begin
			mode = rx_mode_t'($urandom_range(3));
			span = (mode == RX_HOLD) ? $urandom_range(1, 64) : $urandom_range(8, 120);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(1));
					RX_SPARSE: out_ready <= ($urandom_range(7) == 0);
					default:   out_ready <= 1'b0;
				endcase
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

	initial begin
		edge_row_t   rows [DIRECTED_ROWS];
		int unsigned counted;
		int unsigned burst;
		int unsigned ch;
		int unsigned gap;
		logic [7:0]  addr;

		rows = '{
			'{3'd7, 16'hFFFF, 1'b1},
			'{3'd5, 16'h1234, 1'b1},
			'{3'd6, 16'h0000, 1'b1},
			'{3'd0, 16'h0000, 1'b1},
			'{3'd0, 16'h0000, 1'b1},
			'{3'd0, 16'd1300, 1'b0},
			'{3'd0, 16'd2800, 1'b0},
			'{3'd0, 16'd4101, 1'b0},
			'{3'd0, 16'd4202, 1'b0},
			'{3'd0, 16'd4351, 1'b0},
			'{3'd0, 16'd4552, 1'b0},
			'{3'd0, 16'd4801, 1'b0},
			'{3'd0, 16'd4951, 1'b0},
			'{3'd0, 16'd6450, 1'b0},
			'{3'd0, 16'd7850, 1'b0},
			'{3'd0, 16'd8975, 1'b0},
			'{3'd0, 16'd10276, 1'b0},
			'{3'd0, 16'd10376, 1'b0},
			'{3'd4, 16'hFFFF, 1'b1},
			'{3'd4, 16'h0544, 1'b0},
			'{3'd4, 16'h060C, 1'b0},
			'{3'd3, 16'hFF00, 1'b1},
			'{3'd3, 16'h0477, 1'b0},
			'{3'd3, 16'h0571, 1'b0},
			'{3'd2, 16'h8000, 1'b1},
			'{3'd2, 16'h7FFF, 1'b0}
		};

		for (int i = 0; i < NUM_CH; i++) begin
			seen_q[i] = 1'b0;
			last_ts[i] = '0;
			framing[i] = 1'b0;
			nbits[i] = '0;
			shreg[i] = '0;
		end

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_address(8'h00);
		foreach (rows[i])
			push_edge(rows[i].ch, rows[i].ts, rows[i].quiet);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: addr = 8'hFF;
				1: addr = 8'h00;
				default: addr = 8'($urandom);
			endcase
			write_address(addr);
			counted = 0;
			burst = $urandom_range(1, 16);
			while (counted < RANDOM_EDGES / PHASES) begin
				if ($urandom_range(24) == 0) begin
					push_edge(CHAN_W'($urandom_range(NUM_CH, 7)), TIME_W'($urandom), 1'b0);
				end else begin
					ch = $urandom_range(NUM_CH - 1);
					if (pulse_plan[ch].size() == 0) begin
						if ($urandom_range(4) == 0)
							plan_noise(ch);
						else
							plan_frame(ch);
					end
					gap = pulse_plan[ch].pop_front();
					push_edge(CHAN_W'(ch), stamp_after(last_ts[ch], gap), 1'b0);
					counted++;
				end
				burst--;
				if (burst == 0) begin
					idle_input(($urandom_range(9) == 0) ? $urandom_range(20, 60) :
						$urandom_range(0, 6));
					burst = ($urandom_range(5) == 0) ? $urandom_range(60, 200) :
						$urandom_range(1, 16);
				end
				if ($urandom_range(399) == 0)
					drain();
			end
		end

		drain();
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
hdl/nir_pkg.sv
hdl/nir_step.sv
hdl/nir_out_reg.sv
hdl/nec_ir_multichannel_decoder_core.sv
sim/nec_ir_multichannel_decoder_core_tb.sv
